// ----- hdl/rgse_pkg.sv -----
// Shared types, constants and the gray conversion for the Sobel edge stream.
// No dependencies; rgse_sobel and rgb_gray_sobel_edge_stream import this package.
package rgse_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int PIX_W    = 8;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;

    localparam int FRAME_WIDTH_RST  = 1920;
    localparam int FRAME_HEIGHT_RST = 1080;
    localparam int DIM_MIN          = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [7:0] W_BLUE  = 8'b00010010;
    localparam logic [7:0] W_GREEN = 8'b10110111;
    localparam logic [7:0] W_RED   = 8'b00110110;
    localparam int GRAY_SHIFT = 8;
    localparam int EDGE_SHIFT = 3;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [8:0][PIX_W-1:0] t_window;

    function automatic t_pix gray_of(input t_pix b, input t_pix g, input t_pix r);
        logic [15:0] acc;
        acc = 16'(W_BLUE) * 16'(b) + 16'(W_GREEN) * 16'(g) + 16'(W_RED) * 16'(r);
        return PIX_W'(acc >> GRAY_SHIFT);
    endfunction

endpackage

// ----- hdl/rgse_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
module rgse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/rgse_sobel.sv -----
// Sobel 3x3 kernel with L1 magnitude, shifted and saturated to one byte.
// Combinational; depends on rgse_pkg for the window type and shift constant.
module rgse_sobel
    import rgse_pkg::*;
(
    input  t_window i_window,
    output t_pix    o_mag
);

    logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
    logic [9:0]  gx_abs, gy_abs;
    logic [10:0] l1_sum;
    logic [10:0] l1_shr;

    always_comb begin
        gx_pos = 10'(i_window[2]) + 10'({i_window[5], 1'b0}) + 10'(i_window[8]);
        gx_neg = 10'(i_window[0]) + 10'({i_window[3], 1'b0}) + 10'(i_window[6]);
        gy_pos = 10'(i_window[0]) + 10'({i_window[1], 1'b0}) + 10'(i_window[2]);
        gy_neg = 10'(i_window[6]) + 10'({i_window[7], 1'b0}) + 10'(i_window[8]);
        gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        l1_sum = 11'(gx_abs) + 11'(gy_abs);
        l1_shr = l1_sum >> EDGE_SHIFT;
        if (l1_shr > 11'd255) begin
            o_mag = 8'hFF;
        end else begin
            o_mag = l1_shr[PIX_W-1:0];
        end
    end

endmodule

// ----- hdl/rgb_gray_sobel_edge_stream.sv -----
// Streaming BGR to gray conversion followed by a 3x3 Sobel edge detector.
// A result passes stage 1, the window and the output register after its last pixel is taken.
// Throughput: one pixel per unstalled cycle, set by one read and one write port per buffer.
// Reset clears the position counters, the window and all valid flags and loads 1920x1080;
// the line buffers are not cleared. Depends on rgse_pkg, rgse_ram and rgse_sobel.
module rgb_gray_sobel_edge_stream
    import rgse_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_blue,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_red,
    input  logic                 i_start_of_frame,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_edge_res,
    output logic                 o_frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    logic [DW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [DW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    t_pix          r_s1_gray;
    logic          r_s1_emit;
    logic          r_s1_last;
    logic          r_s1_fwd;
    t_pix          r_s1_fwd_above;
    t_pix          r_s1_fwd_two;

    logic          r_s2_valid;
    logic          r_s2_emit;
    logic          r_s2_last;
    t_window       r_window;

    logic          r_out_valid;
    t_pix          r_edge_res;
    logic          r_frame_done;

    logic          accept;
    logic          out_free, s2_free, s1_go, s1_free;
    logic [CW-1:0] a_col, n_col;
    logic [RW-1:0] a_row, n_row;
    logic [RW:0]   row_t;
    logic [CW:0]   col_inc;
    logic          a_emit, a_last;
    t_pix          a_gray;
    t_pix          above_q, two_q, above_val, two_val;
    t_pix          mag;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data < CFG_W'(DIM_MIN)) begin
            cfg_w = DW'(DIM_MIN);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            cfg_w = DW'(MAX_WIDTH);
        end else begin
            cfg_w = DW'(i_cfg_data);
        end
        if (i_cfg_data < CFG_W'(DIM_MIN)) begin
            cfg_h = HW'(DIM_MIN);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            cfg_h = HW'(MAX_HEIGHT);
        end else begin
            cfg_h = HW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= DW'(W_RST);
            r_h <= HW'(H_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_w <= cfg_w;
                REG_FRAME_HEIGHT: r_h <= cfg_h;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign s2_free  = !r_s2_valid || !r_s2_emit || out_free;
    assign s1_go    = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_stall  = !s1_free;
    assign accept   = i_valid && s1_free;

    always_comb begin
        a_col = r_col;
        row_t = (RW+1)'(r_row);
        if (i_start_of_frame) begin
            a_col = '0;
            row_t = '0;
        end else if (32'(r_col) >= 32'(r_w)) begin
            a_col = '0;
            row_t = row_t + 1'b1;
        end
        if (32'(row_t) >= 32'(r_h)) begin
            a_row = '0;
        end else begin
            a_row = row_t[RW-1:0];
        end

        col_inc = (CW+1)'(a_col) + 1'b1;
        n_col   = col_inc[CW-1:0];
        n_row   = a_row;
        if (32'(col_inc) >= 32'(r_w)) begin
            n_col = '0;
            if (32'(a_row) + 1 >= 32'(r_h)) begin
                n_row = '0;
            end else begin
                n_row = a_row + 1'b1;
            end
        end

        a_emit = (32'(a_row) >= 2) && (32'(a_col) >= 2);
        a_last = (32'(a_row) + 1 == 32'(r_h)) && (32'(a_col) + 1 == 32'(r_w));
        a_gray = gray_of(i_blue, i_green, i_red);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    rgse_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_gray),
        .i_rd_en   (accept),
        .i_rd_addr (a_col),
        .o_rd_data (above_q)
    );

    rgse_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (above_val),
        .i_rd_en   (accept),
        .i_rd_addr (a_col),
        .o_rd_data (two_q)
    );

    // A pixel read in the same cycle that its column is written takes the new data.
    assign above_val = r_s1_fwd ? r_s1_fwd_above : above_q;
    assign two_val   = r_s1_fwd ? r_s1_fwd_two : two_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_col       <= a_col;
            r_s1_gray      <= a_gray;
            r_s1_emit      <= a_emit;
            r_s1_last      <= a_last;
            r_s1_fwd       <= s1_go && (r_s1_col == a_col);
            r_s1_fwd_above <= r_s1_gray;
            r_s1_fwd_two   <= above_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_window   <= '0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_go) begin
                r_window[0] <= r_window[1];
                r_window[1] <= r_window[2];
                r_window[2] <= two_val;
                r_window[3] <= r_window[4];
                r_window[4] <= r_window[5];
                r_window[5] <= above_val;
                r_window[6] <= r_window[7];
                r_window[7] <= r_window[8];
                r_window[8] <= r_s1_gray;
            end
        end
        if (s1_go) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
        end
    end

    rgse_sobel u_sobel (
        .i_window (r_window),
        .o_mag    (mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid && r_s2_emit;
        end
        if (out_free && r_s2_valid && r_s2_emit) begin
            r_edge_res   <= mag;
            r_frame_done <= r_s2_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_res   = r_edge_res;
    assign o_frame_done = r_frame_done;

endmodule
